// File: sv/ufr_pkg.sv
// ----------------------------------------------------------------------------
// ufr_pkg
// shared constants and types for the uart frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package ufr_pkg;

  localparam int BUF_DEPTH_DEF = 16;
  localparam int FRAME_LEN     = 8;
  localparam int SUM_LEN       = 6;
  localparam int TICK_W        = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [7:0] HDR0    = 8'hA5;
  localparam logic [7:0] HDR1    = 8'hFA;
  localparam logic [7:0] TRAILER = 8'hFB;

  localparam logic [TICK_W-1:0] IDLE_RESET = 16'd60000;
  localparam logic [TICK_W-1:0] GAP_RESET  = 16'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT  = 2'd1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } result_t;

endpackage

`default_nettype wire

// File: sv/ufr_input_stage.sv
// ----------------------------------------------------------------------------
// ufr_input_stage
// input register holding one byte or tick transaction
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_input_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire ufr_pkg::item_t load_item,
  input  wire logic           advance,
  output logic                item_valid,
  output ufr_pkg::item_t      item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

endmodule

`default_nettype wire

// File: sv/ufr_frame_core.sv
// ----------------------------------------------------------------------------
// ufr_frame_core
// timeout counter, byte store, frame check and configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_frame_core #(
  parameter int BUF_DEPTH = ufr_pkg::BUF_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ufr_pkg::TICK_W-1:0]    cfg_data,
  input  wire logic                          process,
  input  wire ufr_pkg::item_t                item,
  output ufr_pkg::result_t                   result
);

  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int FIDX_W = $clog2(ufr_pkg::FRAME_LEN);

  logic [ufr_pkg::TICK_W-1:0] idle_timeout;
  logic [ufr_pkg::TICK_W-1:0] gap_timeout;
  logic [ufr_pkg::TICK_W-1:0] window_counter;
  logic [ufr_pkg::TICK_W-1:0] window_counter_next;
  logic [ufr_pkg::TICK_W-1:0] counter_dec;
  logic [CNT_W-1:0]           byte_count;
  logic [CNT_W-1:0]           byte_count_next;
  ufr_pkg::frame_t            store;
  logic                       take_byte;
  logic                       write_store;
  logic                       window_close;
  logic                       frame_ok;
  logic [7:0]                 sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= ufr_pkg::IDLE_RESET;
      gap_timeout  <= ufr_pkg::GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ufr_pkg::REG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        ufr_pkg::REG_GAP_TIMEOUT:  gap_timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign counter_dec = window_counter - 1'b1;

  assign take_byte = process && (item.opcode == ufr_pkg::OP_BYTE) &&
                     (window_counter != '0) && (byte_count < CNT_W'(BUF_DEPTH));
  assign write_store = take_byte && (byte_count < CNT_W'(ufr_pkg::FRAME_LEN));
  assign window_close = process && (item.opcode == ufr_pkg::OP_TICK) &&
                        (window_counter == ufr_pkg::TICK_W'(1));

  always_comb begin
    sum = '0;
    for (int i = 0; i < ufr_pkg::SUM_LEN; i++) begin
      sum = sum + store[i];
    end
  end

  assign frame_ok = (byte_count == CNT_W'(ufr_pkg::FRAME_LEN)) &&
                    (store[0] == ufr_pkg::HDR0) && (store[1] == ufr_pkg::HDR1) &&
                    (store[6] == sum) && (store[7] == ufr_pkg::TRAILER);

  always_comb begin
    window_counter_next = window_counter;
    byte_count_next     = byte_count;
    if (take_byte) begin
      window_counter_next = gap_timeout;
      byte_count_next     = byte_count + 1'b1;
    end else if (window_close) begin
      window_counter_next = idle_timeout;
      byte_count_next     = '0;
    end else if (process && (item.opcode == ufr_pkg::OP_TICK) &&
                 (window_counter != '0)) begin
      window_counter_next = counter_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_counter <= ufr_pkg::IDLE_RESET;
      byte_count     <= '0;
    end else begin
      window_counter <= window_counter_next;
      byte_count     <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write_store) begin
      store[byte_count[FIDX_W-1:0]] <= item.rx_byte;
    end
  end

  assign result.valid = window_close && frame_ok;
  assign result.frame = store;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(BUF_DEPTH))
    else $error("byte count above buffer depth");

  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> byte_count == CNT_W'(ufr_pkg::FRAME_LEN))
    else $error("frame emitted without eight bytes");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    window_close |=> byte_count == '0)
    else $error("count not cleared after window close");

  a_closed_drop: assert property (@(posedge clk) disable iff (rst)
    process && item.opcode == ufr_pkg::OP_BYTE && window_counter == '0
    |=> $stable(byte_count))
    else $error("byte taken while window closed");

endmodule

`default_nettype wire

// File: sv/ufr_output_stage.sv
// ----------------------------------------------------------------------------
// ufr_output_stage
// result register toward the frame consumer
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_output_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ufr_pkg::result_t result,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output ufr_pkg::frame_t       out_frame,
  output logic                  out_free
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_frame <= result.frame;
    end
  end

endmodule

`default_nettype wire

// File: sv/uart_frame_receiver_gap_timeout.sv
// ----------------------------------------------------------------------------
// uart_frame_receiver_gap_timeout
// fixed length uart frame receiver closed by a gap or idle timeout
// ----------------------------------------------------------------------------
// usage
//   s_* carries one transaction per byte or tick: tuser[0] = 0 for a received
//   byte in tdata[7:0], 1 for one 10 ms tick (tdata ignored).
//   m_* carries one 8 byte frame per transaction, byte 0 in tdata[7:0].
//   only frames with headers a5 fa, a matching checksum in byte 6 and trailer
//   fb in byte 7 are delivered; all others are dropped silently.
//   cfg_we/cfg_index/cfg_data write the idle (index 0) and gap (index 1)
//   timeouts; write only while no transaction is in flight.
// throughput and result path
//   one transaction is accepted per cycle while s_tready is high; the tick
//   closing a window is held in the input register, checked by the core, and
//   the frame is taken into the result register, which then holds it on m_*.
// reset
//   rst clears both stages, the byte count and loads 60000 idle ticks and
//   2 gap ticks; the window counter starts at 60000.
// stalls
//   while a frame waits with m_tready low the input register holds its
//   transaction and s_tready stays low once it is full; while both are full,
//   s_tready follows m_tready in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_frame_receiver_gap_timeout #(
  parameter int BUF_DEPTH = ufr_pkg::BUF_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // rx_byte
  input  wire logic [0:0]                    s_tuser,   // opcode
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [63:0]                        m_tdata,   // frame_byte0 .. frame_byte7
  input  wire logic                          cfg_we,
  input  wire logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ufr_pkg::TICK_W-1:0]    cfg_data
);

  ufr_pkg::item_t   load_item;
  ufr_pkg::item_t   item;
  ufr_pkg::result_t result;
  ufr_pkg::frame_t  out_frame;
  logic             item_valid;
  logic             out_free;
  logic             advance;
  logic             load;

  assign load_item.opcode  = s_tuser[0];
  assign load_item.rx_byte = s_tdata;

  assign advance  = item_valid && out_free;
  assign s_tready = !item_valid || out_free;
  assign load     = s_tvalid && s_tready;

  ufr_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_item  (load_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ufr_frame_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .process   (advance),
    .item      (item),
    .result    (result)
  );

  ufr_output_stage u_output (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_frame (out_frame),
    .out_free  (out_free)
  );

  assign m_tdata = out_frame;

endmodule

`default_nettype wire
